### rtl/crc8_packet_framer_top_macros.svh
// assertion macros shared by the framer rtl
`ifndef CRC8_PACKET_FRAMER_TOP_MACROS_SVH
`define CRC8_PACKET_FRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CPF_ASSERT_NEVER(label, cond, msg) \
  `CPF_ASSERT(label, !(cond), msg)

`else

`define CPF_ASSERT(label, prop, msg)

`define CPF_ASSERT_NEVER(label, cond, msg)

`endif

`endif

### rtl/crc8pf_pkg.sv
// types, constants and codes shared by the crc-8 packet framer
package crc8pf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;
  localparam logic [7:0] CRC_POLY_RST     = 8'h07;
  localparam logic [7:0] CRC_INIT_RST     = 8'h00;

  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [7:0] {
    CFG_START_MARKER = 8'd0,
    CFG_END_MARKER   = 8'd1,
    CFG_CRC_POLY     = 8'd2,
    CFG_CRC_INIT     = 8'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_BEGIN,
    OP_DATA
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_length;
    logic [7:0] command_id;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_done;
    logic       last_of_run;
  } out_beat_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] len;
    logic [7:0] val;
    logic       close;
  } entry_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] crc_poly;
    logic [7:0] crc_init;
  } cfg_t;

endpackage

### rtl/crc8pf_front.sv
// front end: tracks the open frame and turns input beats into queue entries
module crc8pf_front import crc8pf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_beat_t in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output entry_t   q_entry_o
);

  logic       frame_open_q, frame_open_d;
  logic [7:0] remaining_q, remaining_d;
  logic       accept;
  logic       is_begin;
  logic       last_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_begin   = (in_data_i.kind == KIND_BEGIN);
  assign last_byte  = (remaining_q == 8'd1);

  always_comb begin
    frame_open_d    = frame_open_q;
    remaining_d     = remaining_q;
    q_push_o        = 1'b0;
    q_entry_o.op    = is_begin ? OP_BEGIN : OP_DATA;
    q_entry_o.len   = in_data_i.payload_length;
    q_entry_o.val   = is_begin ? in_data_i.command_id : in_data_i.data_byte;
    q_entry_o.close = is_begin ? (in_data_i.payload_length == 8'd0) : last_byte;
    if (accept) begin
      if (is_begin) begin
        q_push_o     = 1'b1;
        frame_open_d = (in_data_i.payload_length != 8'd0);
        remaining_d  = in_data_i.payload_length;
      end else if (frame_open_q) begin
        q_push_o    = 1'b1;
        remaining_d = remaining_q - 8'd1;
        if (last_byte) begin
          frame_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      remaining_q  <= 8'd0;
    end else begin
      frame_open_q <= frame_open_d;
      remaining_q  <= remaining_d;
    end
  end

endmodule

### rtl/crc8pf_queue.sv
// short entry queue between the front end and the byte emitter
module crc8pf_queue import crc8pf_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   full_o,
  output logic   empty_o
);

`include "crc8_packet_framer_top_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `CPF_ASSERT_NEVER(a_no_push_full, push_i && full_o, "queue pushed while full")
  `CPF_ASSERT_NEVER(a_no_pop_empty, pop_i && empty_o, "queue popped while empty")

endmodule

### rtl/crc8pf_back.sv
// back end: walks each entry through its bytes and keeps the running crc
module crc8pf_back import crc8pf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  entry_t    q_entry_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

`include "crc8_packet_framer_top_macros.svh"

  typedef enum logic [2:0] {
    PH_START,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_CRC,
    PH_END
  } phase_e;

  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  phase_e     phase_q, phase_d, phase_nxt;
  entry_t     cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [7:0] crc_q, crc_d, crc_step;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d, beat;
  logic       emit, fin;

  assign emit = cur_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    beat      = '0;
    crc_step  = crc_q;
    phase_nxt = phase_q;
    fin       = 1'b0;
    case (phase_q)
      PH_START: begin
        beat.out_byte = cfg_i.start_marker;
        crc_step      = crc_feed(cfg_i.crc_init, cur_q.len, cfg_i.crc_poly);
        phase_nxt     = PH_LEN;
      end
      PH_LEN: begin
        beat.out_byte = cur_q.len;
        crc_step      = crc_feed(crc_q, cur_q.val, cfg_i.crc_poly);
        phase_nxt     = PH_CMD;
      end
      PH_CMD: begin
        beat.out_byte    = cur_q.val;
        beat.last_of_run = !cur_q.close;
        fin              = !cur_q.close;
        phase_nxt        = PH_CRC;
      end
      PH_DATA: begin
        beat.out_byte    = cur_q.val;
        beat.last_of_run = !cur_q.close;
        crc_step         = crc_feed(crc_q, cur_q.val, cfg_i.crc_poly);
        fin              = !cur_q.close;
        phase_nxt        = PH_CRC;
      end
      PH_CRC: begin
        beat.out_byte = crc_q;
        phase_nxt     = PH_END;
      end
      PH_END: begin
        beat.out_byte    = cfg_i.end_marker;
        beat.frame_done  = 1'b1;
        beat.last_of_run = 1'b1;
        fin              = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  assign q_pop_o = !q_empty_i && (!cur_valid_q || (emit && fin));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    phase_d     = phase_q;
    crc_d       = emit ? crc_step : crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (q_pop_o) begin
      cur_d       = q_entry_i;
      cur_valid_d = 1'b1;
      phase_d     = (q_entry_i.op == OP_BEGIN) ? PH_START : PH_DATA;
    end else if (emit && fin) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      phase_d = phase_nxt;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = beat;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CPF_ASSERT_NEVER(a_done_is_last, out_q.frame_done && !out_q.last_of_run, "end not last")
  `CPF_ASSERT(a_crc_then_end, emit && phase_q == PH_CRC |=> phase_q == PH_END, "no end after crc")

endmodule

### rtl/crc8_packet_framer_top.sv
// top level of the crc-8 packet framer: config registers and the three parts
// Builds framed byte streams: a begin beat yields start marker, length and command; each
// payload beat is passed through; after the last payload byte (or at once for a zero length)
// the msb-first crc-8 over length, command and payload follows, then the end marker. Output
// runs at one byte per cycle from the back-end emitter unless out_ready_i stalls it; a small
// entry queue (QueueDepth deep) lets the front end keep accepting beats while the emitter
// works or the output stalls. Payload beats with no open frame are dropped without output.
// Config must be written only while idle; the block itself does not enforce it.
module crc8_packet_framer_top import crc8pf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t   cfg_q;
  entry_t push_entry, pop_entry;
  logic   q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= START_MARKER_RST;
      cfg_q.end_marker   <= END_MARKER_RST;
      cfg_q.crc_poly     <= CRC_POLY_RST;
      cfg_q.crc_init     <= CRC_INIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i;
        CFG_END_MARKER:   cfg_q.end_marker   <= cfg_data_i;
        CFG_CRC_POLY:     cfg_q.crc_poly     <= cfg_data_i;
        CFG_CRC_INIT:     cfg_q.crc_init     <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  crc8pf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  crc8pf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  crc8pf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_entry_i   (pop_entry),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
